FILE: rtl/core/rlac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlac_pkg
// Shared types and codes for the radio link advertising controller.
// ----------------------------------------------------------------------------
package rlac_pkg;

    typedef enum logic [2:0] {
        ST_IDLE          = 3'd0,
        ST_STARTING      = 3'd1,
        ST_ADVERTISING   = 3'd2,
        ST_CONNECTING    = 3'd3,
        ST_CONNECTED     = 3'd4,
        ST_STOPPING      = 3'd5,
        ST_DISCONNECTING = 3'd6
    } t_link_state;

    typedef enum logic [3:0] {
        EV_ENABLE        = 4'd0,
        EV_ENABLE_FAST   = 4'd1,
        EV_DISABLE       = 4'd2,
        EV_TIMER         = 4'd3,
        EV_ADV_STARTED   = 4'd4,
        EV_STOPPED_USER  = 4'd5,
        EV_STOPPED_CONN  = 4'd6,
        EV_STOPPED_UNEXP = 4'd7,
        EV_CONNECTED     = 4'd8,
        EV_DISCONNECTED  = 4'd9,
        EV_DISC_REQ      = 4'd10
    } t_event_code;

    localparam logic MODE_NORMAL = 1'b0;
    localparam logic MODE_FAST   = 1'b1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    typedef struct packed {
        logic [3:0] op;
        logic       start_accepted;
        logic       stop_accepted;
        logic       disconnect_accepted;
    } t_event;

    typedef struct packed {
        t_link_state fsm_state;
        logic        enable_wanted;
        logic        mode_wanted;
        logic        mode_requested;
        logic        mode_running;
        logic        drop_link_wanted;
        logic        timer_running;
    } t_ctl_state;

    typedef struct packed {
        logic [2:0] link_state;
        logic       start_adv_cmd;
        logic       start_adv_mode;
        logic       stop_adv_cmd;
        logic       disconnect_cmd;
        logic       timer_start_cmd;
        logic       timer_cancel_cmd;
        logic       wants_enabled;
        logic       wanted_mode;
        logic       current_mode;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/core/rlac_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlac_step
// Next-state and strobe logic for one link event.
// ----------------------------------------------------------------------------
module rlac_step (
    input  var rlac_pkg::t_ctl_state i_state,
    input  var rlac_pkg::t_event     i_event,
    output rlac_pkg::t_ctl_state     o_next,
    output rlac_pkg::t_result        o_result
);
    import rlac_pkg::*;

    t_link_state s;
    t_link_state n_fsm;
    logic        en_ev;
    logic        new_mode;
    logic        s_run_set;
    logic        s_unexp_set;
    logic        s_disc_set;
    logic        issue_start;
    logic        issue_stop;
    logic        issue_disc;
    logic        loss;
    logic        t_start;
    logic        t_cancel;

    always_comb begin
        s           = i_state.fsm_state;
        en_ev       = (i_event.op == EV_ENABLE) || (i_event.op == EV_ENABLE_FAST);
        new_mode    = en_ev ? ((i_event.op == EV_ENABLE_FAST) ? MODE_FAST : MODE_NORMAL)
                            : i_state.mode_wanted;
        s_run_set   = (s == ST_STARTING) || (s == ST_ADVERTISING) || (s == ST_STOPPING);
        s_unexp_set = s_run_set || (s == ST_CONNECTING);
        s_disc_set  = (s == ST_CONNECTING) || (s == ST_CONNECTED)
                    || (s == ST_DISCONNECTING);

        issue_start = (en_ev && s == ST_IDLE)
                    || (i_event.op == EV_TIMER && s == ST_IDLE && i_state.enable_wanted)
                    || (i_event.op == EV_STOPPED_USER && s == ST_STOPPING
                        && i_state.enable_wanted);
        issue_stop  = (en_ev && s == ST_ADVERTISING && i_state.mode_running != new_mode)
                    || (i_event.op == EV_DISABLE && s == ST_ADVERTISING)
                    || (i_event.op == EV_ADV_STARTED && s == ST_STARTING
                        && (!i_state.enable_wanted
                            || i_state.mode_requested != i_state.mode_wanted));
        issue_disc  = (i_event.op == EV_CONNECTED
                       && (!i_state.enable_wanted || i_state.drop_link_wanted))
                    || (i_event.op == EV_DISABLE && s == ST_CONNECTED)
                    || (i_event.op == EV_DISC_REQ && s == ST_CONNECTED);

        // link lost: restart timer if still wanted, otherwise drop it
        loss        = (i_event.op == EV_DISCONNECTED)
                    || (i_event.op == EV_STOPPED_UNEXP && s_unexp_set);
        t_start     = loss && i_state.enable_wanted;
        t_cancel    = (loss && !i_state.enable_wanted)
                    || (i_event.op == EV_CONNECTED)
                    || (en_ev && s == ST_IDLE)
                    || (i_event.op == EV_DISABLE)
                    || (i_event.op == EV_TIMER && s == ST_IDLE)
                    || (i_event.op == EV_ADV_STARTED && s == ST_STARTING);
    end

    // next state
    always_comb begin
        n_fsm = s;
        if (issue_start && i_event.start_accepted) begin
            n_fsm = ST_STARTING;
        end else if (issue_stop && i_event.stop_accepted) begin
            n_fsm = ST_STOPPING;
        end else if (issue_disc && i_event.disconnect_accepted) begin
            n_fsm = ST_DISCONNECTING;
        end else begin
            unique case (i_event.op)
                EV_CONNECTED:     n_fsm = ST_CONNECTED;
                EV_DISCONNECTED:  n_fsm = ST_IDLE;
                EV_STOPPED_CONN:  n_fsm = s_run_set ? ST_CONNECTING : s;
                EV_STOPPED_UNEXP: n_fsm = s_unexp_set ? ST_IDLE : s;
                EV_ADV_STARTED:   n_fsm = (s == ST_STARTING) ? ST_ADVERTISING : s;
                EV_STOPPED_USER:  n_fsm = (s == ST_STOPPING) ? ST_IDLE : s;
                default:          n_fsm = s;
            endcase
        end
    end

    // state flags and strobes
    always_comb begin
        o_next           = i_state;
        o_next.fsm_state = n_fsm;
        o_next.mode_wanted = new_mode;
        if (en_ev || (i_event.op == EV_DISC_REQ && s_disc_set)) begin
            o_next.enable_wanted = 1'b1;
        end else if (i_event.op == EV_DISABLE) begin
            o_next.enable_wanted = 1'b0;
        end
        if (i_event.op == EV_DISC_REQ && s_disc_set) begin
            o_next.drop_link_wanted = 1'b1;
        end else if (i_event.op == EV_DISABLE || i_event.op == EV_DISCONNECTED) begin
            o_next.drop_link_wanted = 1'b0;
        end
        if (issue_start && i_event.start_accepted) begin
            o_next.mode_requested = new_mode;
        end
        if (i_event.op == EV_ADV_STARTED && s == ST_STARTING) begin
            o_next.mode_running = i_state.mode_requested;
        end
        if (t_start) begin
            o_next.timer_running = 1'b1;
        end else if (t_cancel) begin
            o_next.timer_running = 1'b0;
        end

        o_result.link_state       = n_fsm;
        o_result.start_adv_cmd    = issue_start;
        o_result.start_adv_mode   = issue_start & new_mode;
        o_result.stop_adv_cmd     = issue_stop;
        o_result.disconnect_cmd   = issue_disc;
        o_result.timer_start_cmd  = t_start & ~i_state.timer_running;
        o_result.timer_cancel_cmd = t_cancel & i_state.timer_running;
        o_result.wants_enabled    = o_next.enable_wanted;
        o_result.wanted_mode      = o_next.mode_wanted;
        o_result.current_mode     = o_next.mode_running;
    end

endmodule
`default_nettype wire

FILE: rtl/core/radio_link_advertising_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// The result of an accepted input transaction reaches the output through the
// input register, then the result register.
// Throughput: one event per clock cycle; each cycle of output stall holds
// s_axis_tready low once the input register is occupied, as it is in a stream.
// Reset (i_rst_n low, synchronous) returns the controller to idle with all
// wanted/pending flags and modes cleared and both registers empty.
// ----------------------------------------------------------------------------
// radio_link_advertising_controller
// Advertising and connection controller driven by one link event per item.
// ----------------------------------------------------------------------------
module radio_link_advertising_controller (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] op, [4] start_accepted, [5] stop_accepted, [6] disconnect_accepted
    input  wire  [rlac_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [2:0] link_state, [3] start_adv_cmd, [4] start_adv_mode, [5] stop_adv_cmd,
    // [6] disconnect_cmd, [7] timer_start_cmd, [8] timer_cancel_cmd,
    // [9] wants_enabled, [10] wanted_mode, [11] current_mode
    output logic [rlac_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rlac_pkg::*;

    logic       r_in_valid;
    t_event     r_in;
    logic       r_out_valid;
    t_result    r_out;
    t_ctl_state r_state;
    t_ctl_state n_state;
    t_result    n_out;
    logic       advance;

    rlac_step u_step (
        .i_state  (r_state),
        .i_event  (r_in),
        .o_next   (n_state),
        .o_result (n_out)
    );

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.op                  <= s_axis_tdata[3:0];
            r_in.start_accepted      <= s_axis_tdata[4];
            r_in.stop_accepted       <= s_axis_tdata[5];
            r_in.disconnect_accepted <= s_axis_tdata[6];
        end
    end

    // commit the state only when the result moves into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{fsm_state: ST_IDLE, default: 1'b0};
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tdata = {4'b0000,
                           r_out.current_mode,
                           r_out.wanted_mode,
                           r_out.wants_enabled,
                           r_out.timer_cancel_cmd,
                           r_out.timer_start_cmd,
                           r_out.disconnect_cmd,
                           r_out.stop_adv_cmd,
                           r_out.start_adv_mode,
                           r_out.start_adv_cmd,
                           r_out.link_state};

`ifndef SYNTHESIS
    a_one_adv_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_out.start_adv_cmd && r_out.stop_adv_cmd))
        else $error("start and stop advertising requested together");

    a_timer_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_out.timer_start_cmd && r_out.timer_cancel_cmd))
        else $error("timer started and cancelled together");

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance) |=> r_out_valid)
        else $error("transaction lost between input and result register");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("held input transaction overwritten");
`endif

endmodule
`default_nettype wire
